### rtl/checksummed_sentence_decoder_core_macros.svh
// Assertion macros for the checksummed sentence decoder.
// Each macro expects clk and rst_n in the scope of its use.
`ifndef CHECKSUMMED_SENTENCE_DECODER_CORE_MACROS_SVH
`define CHECKSUMMED_SENTENCE_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/csd_pkg.sv
// Shared types, character codes and helpers for the sentence decoder.
// No dependencies.
package csd_pkg;

  typedef enum logic [2:0] {
    PH_WAIT     = 3'd0,
    PH_RECORD   = 3'd1,
    PH_HEX_HIGH = 3'd2,
    PH_HEX_LOW  = 3'd3,
    PH_CLOSE    = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_WAITING   = 3'd0,
    ST_PARSING   = 3'd1,
    ST_FAILURE   = 3'd2,
    ST_COORD     = 3'd3,
    ST_HIT       = 3'd4,
    ST_CHALLENGE = 3'd5,
    ST_DETERMINE = 3'd6
  } status_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_E      = 8'h45;

  localparam logic [7:0] OFS_DIGIT = 8'd48;
  localparam logic [7:0] OFS_UPPER = 8'd55;
  localparam logic [7:0] OFS_LOWER = 8'd87;
  localparam logic [4:0] HEX_BAD   = 5'd16;

  // 0..15 for a hex digit, HEX_BAD otherwise
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      d = c - OFS_DIGIT;
    end else if (c inside {[CH_UA:CH_UF]}) begin
      d = c - OFS_UPPER;
    end else if (c inside {[CH_LA:CH_LF]}) begin
      d = c - OFS_LOWER;
    end else begin
      d = {3'b000, HEX_BAD};
    end
    return d[4:0];
  endfunction

endpackage

### rtl/csd_in_if.sv
// Input channel of the sentence decoder: one received byte per word.
// No dependencies.
interface csd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/csd_out_if.sv
// Result channel of the sentence decoder: status and three field values per word.
// No dependencies.
interface csd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] first_value;
  logic [15:0] second_value;
  logic [15:0] third_value;

  modport source (output valid, output status, output first_value, output second_value,
                  output third_value, input ready);
  modport sink   (input valid, input status, input first_value, input second_value,
                  input third_value, output ready);
endinterface

### rtl/checksummed_sentence_decoder_core.sv
// Sentence decoder core: $TAG,a,b[,c]*hh parser with XOR checksum and field values.
// Depends on csd_pkg, csd_in_if, csd_out_if and the assertion macro header.
//
//  channel | dir | handshake     | word
//  in_ch   | in  | valid/ready   | rx_byte[7:0]
//  out_ch  | out | valid/ready   | status[2:0], first/second/third_value[15:0]
//
// One result word per input word, in the cycle after it is taken; a word can be
// taken every cycle unless out_ch stalls a held result. The result sits in a single register.
// in_ch.ready is high while the result register is empty or being drained.
// Reset (rst_n low, synchronous) returns to waiting for '$' and empties the output.
`include "checksummed_sentence_decoder_core_macros.svh"

module checksummed_sentence_decoder_core #(
  parameter int MAX_PAYLOAD = 64
) (
  input logic      clk,
  input logic      rst_n,
  csd_in_if.sink   in_ch,
  csd_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

  csd_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [3:0]       hi_r, hi_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       tag_r [2];
  logic [7:0]       tag_nxt [2];
  logic [1:0]       fnum_r, fnum_nxt;
  logic [15:0]      field_r [3];
  logic [15:0]      field_nxt [3];
  logic             ended_r, ended_nxt;
  logic             ck_ok_r, ck_ok_nxt;

  logic             out_valid_r;
  csd_pkg::status_t status_r, status_nxt;
  logic [15:0]      v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;

  logic             take;
  logic [7:0]       c;
  logic [4:0]       hex;
  logic             hex_ok;
  logic             sum_match;
  logic             is_digit;
  logic [3:0]       digit;
  logic [1:0]       fidx;
  logic [15:0]      fcur;
  logic [19:0]      acc;
  logic [15:0]      fsat;

  logic             in_wait;
  logic             idle_byte;
  logic             waiting_word;
  logic             plain_status;
  logic             hit_status;
  logic             values_zero;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign c           = in_ch.rx_byte;

  assign hex       = csd_pkg::hex_value(c);
  assign hex_ok    = !hex[4];
  assign sum_match = hex_ok && ({hi_r, hex[3:0]} == xor_r);
  assign is_digit  = (c >= csd_pkg::CH_ZERO) && (c <= csd_pkg::CH_NINE);
  assign digit     = 4'(c - csd_pkg::OFS_DIGIT);
  assign fidx      = fnum_r - 2'd1;
  assign fcur      = field_r[fidx];
  assign acc       = ({4'b0000, fcur} << 3) + ({4'b0000, fcur} << 1) + {16'h0000, digit};
  assign fsat      = (acc[19:16] != 4'h0) ? 16'hFFFF : acc[15:0];

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      csd_pkg::PH_WAIT: begin
        if (c == csd_pkg::CH_DOLLAR) phase_nxt = csd_pkg::PH_RECORD;
      end
      csd_pkg::PH_RECORD: begin
        if (c == csd_pkg::CH_STAR) phase_nxt = csd_pkg::PH_HEX_HIGH;
        else if (count_r >= CNT_W'(MAX_PAYLOAD)) phase_nxt = csd_pkg::PH_WAIT;
      end
      csd_pkg::PH_HEX_HIGH: begin
        phase_nxt = hex_ok ? csd_pkg::PH_HEX_LOW : csd_pkg::PH_WAIT;
      end
      csd_pkg::PH_HEX_LOW: begin
        phase_nxt = sum_match ? csd_pkg::PH_CLOSE : csd_pkg::PH_WAIT;
      end
      default: begin
        phase_nxt = csd_pkg::PH_WAIT;
      end
    endcase
  end

  // sentence state and result word
  always_comb begin
    xor_nxt      = xor_r;
    hi_nxt       = hi_r;
    count_nxt    = count_r;
    tag_nxt      = tag_r;
    fnum_nxt     = fnum_r;
    field_nxt    = field_r;
    ended_nxt    = ended_r;
    ck_ok_nxt    = ck_ok_r;
    status_nxt   = csd_pkg::ST_PARSING;
    v1_nxt       = 16'h0000;
    v2_nxt       = 16'h0000;
    v3_nxt       = 16'h0000;
    case (phase_r)
      csd_pkg::PH_WAIT: begin
        if (c == csd_pkg::CH_DOLLAR) begin
          xor_nxt   = 8'h00;
          hi_nxt    = 4'h0;
          count_nxt = '0;
          tag_nxt   = '{8'h00, 8'h00};
          fnum_nxt  = 2'd0;
          field_nxt = '{16'h0000, 16'h0000, 16'h0000};
          ended_nxt = 1'b0;
          ck_ok_nxt = 1'b0;
        end else begin
          status_nxt = csd_pkg::ST_WAITING;
        end
      end
      csd_pkg::PH_RECORD: begin
        if (c == csd_pkg::CH_STAR) begin
          status_nxt = csd_pkg::ST_PARSING;
        end else if (count_r >= CNT_W'(MAX_PAYLOAD)) begin
          status_nxt = csd_pkg::ST_FAILURE;
        end else begin
          xor_nxt   = xor_r ^ c;
          count_nxt = count_r + CNT_W'(1);
          if (count_r < CNT_W'(2)) tag_nxt[count_r[0]] = c;
          if (c == csd_pkg::CH_COMMA) begin
            if (fnum_r != 2'd3) begin
              fnum_nxt  = fnum_r + 2'd1;
              ended_nxt = 1'b0;
            end else begin
              ended_nxt = 1'b1;
            end
          end else if ((fnum_r != 2'd0) && !ended_r) begin
            if (is_digit) field_nxt[fidx] = fsat;
            else ended_nxt = 1'b1;
          end
        end
      end
      csd_pkg::PH_HEX_HIGH: begin
        if (hex_ok) hi_nxt = hex[3:0];
        else status_nxt = csd_pkg::ST_FAILURE;
      end
      csd_pkg::PH_HEX_LOW: begin
        ck_ok_nxt = sum_match;
        if (!sum_match) status_nxt = csd_pkg::ST_FAILURE;
      end
      default: begin
        if (tag_r[0] == csd_pkg::CH_C && tag_r[1] == csd_pkg::CH_O) begin
          status_nxt = csd_pkg::ST_COORD;
        end else if (tag_r[0] == csd_pkg::CH_H && tag_r[1] == csd_pkg::CH_I) begin
          status_nxt = csd_pkg::ST_HIT;
        end else if (tag_r[0] == csd_pkg::CH_C && tag_r[1] == csd_pkg::CH_H) begin
          status_nxt = csd_pkg::ST_CHALLENGE;
        end else if (tag_r[0] == csd_pkg::CH_D && tag_r[1] == csd_pkg::CH_E) begin
          status_nxt = csd_pkg::ST_DETERMINE;
        end else begin
          status_nxt = csd_pkg::ST_FAILURE;
        end
        if (status_nxt != csd_pkg::ST_FAILURE) begin
          v1_nxt = field_r[0];
          v2_nxt = field_r[1];
          if (status_nxt == csd_pkg::ST_HIT) v3_nxt = field_r[2];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= csd_pkg::PH_WAIT;
      xor_r   <= 8'h00;
      hi_r    <= 4'h0;
      count_r <= '0;
      tag_r   <= '{8'h00, 8'h00};
      fnum_r  <= 2'd0;
      field_r <= '{16'h0000, 16'h0000, 16'h0000};
      ended_r <= 1'b0;
      ck_ok_r <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      hi_r    <= hi_nxt;
      count_r <= count_nxt;
      tag_r   <= tag_nxt;
      fnum_r  <= fnum_nxt;
      field_r <= field_nxt;
      ended_r <= ended_nxt;
      ck_ok_r <= ck_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the result word until taken
  always_ff @(posedge clk) begin
    if (take) begin
      status_r <= status_nxt;
      v1_r     <= v1_nxt;
      v2_r     <= v2_nxt;
      v3_r     <= v3_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.first_value  = v1_r;
  assign out_ch.second_value = v2_r;
  assign out_ch.third_value  = v3_r;

  assign in_wait      = (phase_r == csd_pkg::PH_WAIT);
  assign idle_byte    = take && in_wait && (c != csd_pkg::CH_DOLLAR);
  assign waiting_word = out_valid_r && (status_r == csd_pkg::ST_WAITING);
  assign plain_status = status_r inside {csd_pkg::ST_WAITING, csd_pkg::ST_PARSING,
                                         csd_pkg::ST_FAILURE};
  assign hit_status   = (status_r == csd_pkg::ST_HIT);
  assign values_zero  = (v1_r == 16'h0000) && (v2_r == 16'h0000) && (v3_r == 16'h0000);

  `CSD_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_PAYLOAD), "payload count overrun")
  `CSD_ASSERT_SAME(a_close_needs_sum, phase_r == csd_pkg::PH_CLOSE, ck_ok_r, "unchecked close")
  `CSD_ASSERT_SAME(a_values_zero, out_valid_r && plain_status, values_zero, "values on plain status")
  `CSD_ASSERT_SAME(a_v3_hit, out_valid_r && !hit_status, v3_r == 16'h0000, "third value off hit")
  `CSD_ASSERT_NEXT(a_idle_byte, idle_byte, waiting_word && in_wait, "idle byte mishandled")

endmodule
